/* hw/rtl/rv32i_instruction_step_macros.svh */
// assertion macros for the instruction step block
`ifndef RV32I_INSTRUCTION_STEP_MACROS_SVH
`define RV32I_INSTRUCTION_STEP_MACROS_SVH
`ifndef ASSERT_OFF
`define RIS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RIS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RIS_ASSERT(label, clk, rst, prop, msg)
`define RIS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/ris_pkg.sv */
package ris_pkg;

   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   localparam logic [6:0] OPC_FENCE  = 7'h0F;
   localparam logic [6:0] FUNCT7_ALT = 7'h20;
   localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;
   localparam logic [31:0] EXIT_RESET = 32'd10;
   localparam logic [4:0] REG_CALL_NUMBER = 5'd17;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_HALT    = 3'd1;
   localparam logic [2:0] ST_EXIT    = 3'd2;
   localparam logic [2:0] ST_ILLEGAL = 3'd3;
   localparam logic [2:0] ST_RANGE   = 3'd4;
   localparam logic [2:0] ST_HALTED  = 3'd5;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE, PH_CLEAR, PH_FETCH, PH_EXEC, PH_DATA, PH_OUT
   } phase_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] instr_pc;
      logic [31:0] instr_word;
      logic        reg_written;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic [31:0] next_pc;
      logic        is_halted;
   } rsp_type;

   typedef struct packed {
      logic        cmd;
      logic [11:0] load_address;
      logic [31:0] load_data;
   } req_type;

   function automatic logic [31:0] alu_op(input logic [2:0] f3, input logic alt,
                                          input logic [31:0] a, input logic [31:0] b);
      logic [31:0] r;
      case (f3)
         3'd0: r = alt ? a - b : a + b;
         3'd1: r = a << b[4:0];
         3'd2: r = {31'd0, $signed(a) < $signed(b)};
         3'd3: r = {31'd0, a < b};
         3'd4: r = a ^ b;
         3'd5: r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
         3'd6: r = a | b;
         default: r = a & b;
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/ris_stream_if.sv */
interface ris_stream_if #(parameter int unsigned WIDTH = 1);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/rv32i_instruction_step.sv */
// RV32I step engine. A load transaction writes a program word and frees the input
// once its result moves to the output register; a step transaction runs fetch issue,
// word and register read, execute and result, plus a data phase for a load instruction,
// whose data comes back through the single byte-memory port. Stores add no phase.
// After reset a clearing pass zeroes the byte memory and the register file, during
// which no transaction is taken. Results sit in an output register; the next
// request is taken while a result waits, and the engine holds its finished result
// until the output register frees.
module rv32i_instruction_step #(
   parameter int unsigned MEM_BYTES = 4096
) (
   input  logic   clock,
   input  logic   reset,
   ris_stream_if.sink   req,
   ris_stream_if.source rsp,
   input  logic   csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import ris_pkg::*;
   `include "rv32i_instruction_step_macros.svh"

   localparam int unsigned AW = $clog2(MEM_BYTES);
   localparam int unsigned ROWS = MEM_BYTES / 4;
   localparam int unsigned CW = AW - 1;
   localparam int unsigned CLR_LAST = (ROWS > 32) ? ROWS - 1 : 31;

   phase_type phase_ff, phase_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [31:0] exit_ff, pc_ff, pc_in;
   logic halt_ff, halt_in;
   req_type req_ff, req_in, reqp;
   logic [31:0] word_ff, word_in, addr_ff, addr_in;
   logic [2:0] f3_ff, f3_in;
   logic is_load_ff, is_load_in;
   rsp_type res_ff, res_in, out_ff, out_in;
   logic out_v_ff, out_v_in;
   logic [AW-1:0] m_addr;
   logic [3:0] m_we;
   logic [31:0] m_wd, m_rd, ra, rb;
   logic rf_we;
   logic [4:0] rf_wa;
   logic [31:0] rf_wd;
   logic [4:0] rf_rb_addr;
   logic take_req;

   assign reqp = req.payload;

   // rs2, or the call number register for a system instruction
   assign rf_rb_addr = (m_rd[6:0] == OPC_SYSTEM) ? REG_CALL_NUMBER : m_rd[24:20];

   ris_byte_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
      .clock, .addr(m_addr), .wr_en(m_we), .wr_data(m_wd), .rd_data(m_rd));
   ris_reg_file u_rf (
      .clock, .rd_addr_a(m_rd[19:15]), .rd_addr_b(rf_rb_addr),
      .rd_data_a(ra), .rd_data_b(rb), .wr_en(rf_we), .wr_addr(rf_wa), .wr_data(rf_wd));

   assign req.ready = (phase_ff == PH_IDLE);
   assign take_req = req.valid && req.ready;
   assign rsp.valid = out_v_ff;
   assign rsp.payload = out_ff;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CLEAR;
         clr_ff <= '0;
         exit_ff <= EXIT_RESET;
         pc_ff <= '0;
         halt_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         clr_ff <= clr_in;
         if (csr_write_enable) exit_ff <= csr_write_data;
         pc_ff <= pc_in;
         halt_ff <= halt_in;
         out_v_ff <= out_v_in;
      end
      req_ff <= req_in;
      word_ff <= word_in;
      addr_ff <= addr_in;
      f3_ff <= f3_in;
      is_load_ff <= is_load_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   // sequencer
   always_comb begin
      logic [6:0] op;
      logic [2:0] f3;
      logic [31:0] w, immi, imms, immb, immj, ea, wrd;
      logic [2:0] sz;
      logic tk;
      phase_in = phase_ff; clr_in = clr_ff; pc_in = pc_ff; halt_in = halt_ff;
      req_in = req_ff; word_in = word_ff; addr_in = addr_ff; f3_in = f3_ff;
      is_load_in = is_load_ff; res_in = res_ff; out_in = out_ff;
      out_v_in = out_v_ff && !rsp.ready;
      m_addr = AW'(req_ff.load_address); m_we = 4'd0; m_wd = req_ff.load_data;
      rf_we = 1'b0; rf_wa = res_ff.dest_index; rf_wd = res_ff.dest_value;
      w = m_rd; op = w[6:0]; f3 = w[14:12];
      immi = {{20{w[31]}}, w[31:20]};
      imms = {{20{w[31]}}, w[31:25], w[11:7]};
      immb = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      immj = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      ea = '0; sz = 3'd4; tk = 1'b0; wrd = '0;
      unique case (phase_ff)
         PH_CLEAR: begin
            m_addr = AW'({clr_ff, 2'b00});
            m_we = 4'hF; m_wd = '0;
            rf_we = 1'b1; rf_wa = clr_ff[4:0]; rf_wd = '0;
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(CLR_LAST)) phase_in = PH_IDLE;
         end
         PH_IDLE: begin
            if (take_req) begin
               req_in = reqp;
               res_in = '0;
               res_in.next_pc = pc_ff;
               res_in.is_halted = halt_ff;
               res_in.instr_pc = pc_ff;
               if (reqp.cmd == CMD_LOAD) begin
                  res_in.instr_pc = '0;
                  if ({1'b0, reqp.load_address} <= 13'(MEM_BYTES - 4)) begin
                     m_addr = AW'(reqp.load_address);
                     m_we = 4'hF; m_wd = reqp.load_data;
                  end else res_in.status = ST_RANGE;
                  phase_in = PH_OUT;
               end else if (halt_ff) begin
                  res_in.status = ST_HALTED;
                  phase_in = PH_OUT;
               end else if (pc_ff > 32'(MEM_BYTES - 4)) begin
                  res_in.status = ST_HALT;
                  res_in.is_halted = 1'b1;
                  halt_in = 1'b1;
                  phase_in = PH_OUT;
               end else begin
                  m_addr = pc_ff[AW-1:0];
                  phase_in = PH_FETCH;
               end
            end
         end
         PH_FETCH: begin
            // word arrives; start register read
            word_in = m_rd;
            phase_in = PH_EXEC;
         end
         PH_EXEC: begin
            w = word_ff; op = w[6:0]; f3 = w[14:12];
            immi = {{20{w[31]}}, w[31:20]};
            imms = {{20{w[31]}}, w[31:25], w[11:7]};
            immb = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
            immj = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
            res_in.instr_word = w;
            res_in.dest_index = w[11:7];
            res_in.next_pc = pc_ff + 32'd4;
            phase_in = PH_OUT;
            if (w == '0) begin
               res_in.status = ST_HALT; res_in.is_halted = 1'b1; halt_in = 1'b1;
               res_in.next_pc = pc_ff; res_in.dest_index = '0;
            end else begin
               unique case (op) inside
                  OPC_OPIMM: begin
                     tk = 1'b1;
                     if (f3 == 3'd1 || f3 == 3'd5)
                        wrd = alu_op(f3, w[30], ra, {27'd0, w[24:20]});
                     else wrd = alu_op(f3, 1'b0, ra, immi);
                  end
                  OPC_OP: begin
                     tk = 1'b1;
                     wrd = alu_op(f3, w[31:25] == FUNCT7_ALT, ra, rb);
                  end
                  OPC_LOAD, OPC_STORE: begin
                     ea = ra + ((op == OPC_LOAD) ? immi : imms);
                     sz = (f3[1:0] == 2'd0) ? 3'd1 : ((f3[1:0] == 2'd1) ? 3'd2 : 3'd4);
                     if ((op == OPC_LOAD && (f3 == 3'd3 || f3 >= 3'd6)) ||
                         (op == OPC_STORE && f3 > 3'd2))
                        res_in.status = ST_ILLEGAL;
                     else if (ea > 32'(MEM_BYTES) - {29'd0, sz})
                        res_in.status = ST_RANGE;
                     else begin
                        m_addr = ea[AW-1:0];
                        m_wd = rb;
                        if (op == OPC_STORE)
                           m_we = (sz == 3'd1) ? 4'h1 : ((sz == 3'd2) ? 4'h3 : 4'hF);
                        addr_in = ea; f3_in = f3;
                        is_load_in = (op == OPC_LOAD);
                        if (op == OPC_LOAD) phase_in = PH_DATA;
                     end
                  end
                  OPC_BRANCH: begin
                     case (f3)
                        3'd0: tk = ra == rb;
                        3'd1: tk = ra != rb;
                        3'd4: tk = $signed(ra) < $signed(rb);
                        3'd5: tk = !($signed(ra) < $signed(rb));
                        3'd6: tk = ra < rb;
                        3'd7: tk = ra >= rb;
                        default: res_in.status = ST_ILLEGAL;
                     endcase
                     if (tk) res_in.next_pc = pc_ff + immb;
                     tk = 1'b0;
                  end
                  OPC_JAL: begin
                     tk = 1'b1; wrd = pc_ff + 32'd4; res_in.next_pc = pc_ff + immj;
                  end
                  OPC_JALR: begin
                     tk = 1'b1; wrd = pc_ff + 32'd4;
                     res_in.next_pc = (ra + immi) & ~32'd1;
                  end
                  OPC_LUI: begin tk = 1'b1; wrd = w & UPPER_MASK; end
                  OPC_AUIPC: begin tk = 1'b1; wrd = pc_ff + (w & UPPER_MASK); end
                  OPC_FENCE: ;
                  OPC_SYSTEM: begin
                     // port b carries x17 for a system instruction
                     if (rb == exit_ff) begin
                        res_in.status = ST_EXIT; res_in.is_halted = 1'b1;
                        halt_in = 1'b1;
                     end
                  end
                  default: res_in.status = ST_ILLEGAL;
               endcase
               if (tk && w[11:7] != 5'd0) begin
                  res_in.reg_written = 1'b1;
                  res_in.dest_value = wrd;
                  rf_we = 1'b1; rf_wa = w[11:7]; rf_wd = wrd;
               end else if (phase_in != PH_DATA) res_in.dest_index = '0;
            end
            pc_in = res_in.next_pc;
         end
         PH_DATA: begin
            case (f3_ff)
               3'd0: wrd = {{24{m_rd[7]}}, m_rd[7:0]};
               3'd1: wrd = {{16{m_rd[15]}}, m_rd[15:0]};
               3'd4: wrd = {24'd0, m_rd[7:0]};
               3'd5: wrd = {16'd0, m_rd[15:0]};
               default: wrd = m_rd;
            endcase
            if (res_in.dest_index != 5'd0) begin
               res_in.reg_written = 1'b1; res_in.dest_value = wrd;
               rf_we = 1'b1; rf_wa = res_ff.dest_index; rf_wd = wrd;
            end else res_in.dest_index = '0;
            phase_in = PH_OUT;
         end
         PH_OUT: begin
            if (!out_v_ff || rsp.ready) begin
               out_in = res_ff; out_v_in = 1'b1; phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   `RIS_ASSERT(a_out_hold, clock, reset, out_v_ff && !rsp.ready |=> out_v_ff, "result lost")
   `RIS_ASSERT(a_no_take_busy, clock, reset, phase_ff != PH_IDLE |-> !req.ready, "ready busy")
   `RIS_ASSERT(a_halt_sticky, clock, reset, halt_ff |=> halt_ff, "halt cleared")
endmodule

/* hw/rtl/ris_byte_mem.sv */
// four byte lanes, word-interleaved, one access per cycle, registered read
module ris_byte_mem #(
   parameter int unsigned MEM_BYTES = 4096
) (
   input  logic                         clock,
   input  logic [$clog2(MEM_BYTES)-1:0] addr,
   input  logic [3:0]                   wr_en,
   input  logic [31:0]                  wr_data,
   output logic [31:0]                  rd_data
);
   localparam int unsigned AW = $clog2(MEM_BYTES);
   localparam int unsigned ROWS = MEM_BYTES / 4;
   localparam int unsigned RW = AW - 2;

   logic [7:0] lane0 [ROWS];
   logic [7:0] lane1 [ROWS];
   logic [7:0] lane2 [ROWS];
   logic [7:0] lane3 [ROWS];
   logic [RW-1:0] row_a, row_b;
   logic [1:0] off_ff;
   logic [7:0] q0_ff, q1_ff, q2_ff, q3_ff;
   logic [31:0] rot;

   // rows for lanes at/above and below the byte offset
   assign row_a = addr[AW-1:2];
   assign row_b = addr[AW-1:2] + RW'(1);

   // lane k holds byte (addr + ((k - off) mod 4))
   always_ff @(posedge clock) begin
      logic [RW-1:0] r0, r1, r2, r3;
      logic [1:0] b0, b1, b2, b3;
      r0 = (addr[1:0] > 2'd0) ? row_b : row_a;
      r1 = (addr[1:0] > 2'd1) ? row_b : row_a;
      r2 = (addr[1:0] > 2'd2) ? row_b : row_a;
      r3 = row_a;
      b0 = 2'd0 - addr[1:0];
      b1 = 2'd1 - addr[1:0];
      b2 = 2'd2 - addr[1:0];
      b3 = 2'd3 - addr[1:0];
      if (wr_en[b0]) lane0[r0] <= wr_data[8*b0 +: 8];
      if (wr_en[b1]) lane1[r1] <= wr_data[8*b1 +: 8];
      if (wr_en[b2]) lane2[r2] <= wr_data[8*b2 +: 8];
      if (wr_en[b3]) lane3[r3] <= wr_data[8*b3 +: 8];
      q0_ff <= lane0[r0];
      q1_ff <= lane1[r1];
      q2_ff <= lane2[r2];
      q3_ff <= lane3[r3];
      off_ff <= addr[1:0];
   end

   // rotate lanes back to byte order
   always_comb begin
      rot = {q3_ff, q2_ff, q1_ff, q0_ff};
      rd_data = (rot >> (8 * off_ff)) | (rot << (8 * (3'd4 - {1'b0, off_ff})));
   end
endmodule

/* hw/rtl/ris_reg_file.sv */
// register file, two synchronous read ports, one write port
module ris_reg_file (
   input  logic        clock,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);
   logic [31:0] regs [32];

   always_ff @(posedge clock) begin
      if (wr_en) regs[wr_addr] <= wr_data;
      rd_data_a <= regs[rd_addr_a];
      rd_data_b <= regs[rd_addr_b];
   end
endmodule

/* tb/step_checker.sv */
`timescale 1ns / 1ps

module step_checker
   import ris_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_payload,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   output int          fail_count,
   output int          pending_results,
   output int          results_seen
);

   // mirror of the core's architectural state
   logic [31:0] regs [32];
   logic [7:0]  mem_bytes [4096];
   logic [31:0] pc_mirror;
   logic        halted_mirror;
   logic [31:0] exit_number;
   rsp_type     expected_rsps [$];

   initial begin
      for (int i = 0; i < 32; i++) regs[i] = '0;
      for (int i = 0; i < 4096; i++) mem_bytes[i] = '0;
      pc_mirror = '0;
      halted_mirror = 1'b0;
      exit_number = EXIT_RESET;
      fail_count = 0;
      results_seen = 0;
   end

   function automatic logic fits(input logic [31:0] addr, input logic [31:0] size);
      return addr <= 32'd4096 - size;
   endfunction

   function automatic logic [31:0] read_bytes(input logic [31:0] addr, input int size);
      logic [31:0] v;
      v = '0;
      for (int i = 0; i < size; i++) v[8*i +: 8] = mem_bytes[addr + i];
      return v;
   endfunction

   function automatic void write_bytes(input logic [31:0] addr, input int size,
                                       input logic [31:0] v);
      for (int i = 0; i < size; i++) mem_bytes[addr + i] = v[8*i +: 8];
   endfunction

   function automatic logic [31:0] compute_alu(input logic [2:0] f3, input logic alt,
                                               input logic [31:0] a, input logic [31:0] b);
      case (f3)
         3'd0: return alt ? a - b : a + b;
         3'd1: return a << b[4:0];
         3'd2: return {31'd0, $signed(a) < $signed(b)};
         3'd3: return {31'd0, a < b};
         3'd4: return a ^ b;
         3'd5: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
         3'd6: return a | b;
         default: return a & b;
      endcase
   endfunction

   // execute one transaction against the mirror and return what the core reports
   function automatic rsp_type execute_step(input req_type t);
      rsp_type r;
      logic [31:0] w, a, b, imm_i, imm_s, imm_b, imm_j, addr, v;
      logic [6:0]  op;
      logic [2:0]  f3;
      logic        wr, take;
      int          size;
      r = '0;
      wr = 1'b0;
      r.instr_pc = pc_mirror;
      r.next_pc = pc_mirror;
      if (t.cmd == CMD_LOAD) begin
         if (fits({20'd0, t.load_address}, 4)) write_bytes({20'd0, t.load_address}, 4, t.load_data);
         else r.status = ST_RANGE;
         r.instr_pc = '0;
      end else if (halted_mirror) begin
         r.status = ST_HALTED;
      end else if (!fits(pc_mirror, 4)) begin
         r.status = ST_HALT;
         halted_mirror = 1'b1;
      end else begin
         w = read_bytes(pc_mirror, 4);
         r.instr_word = w;
         if (w == '0) begin
            r.status = ST_HALT;
            halted_mirror = 1'b1;
         end else begin
            op = w[6:0];
            f3 = w[14:12];
            a = regs[w[19:15]];
            b = regs[w[24:20]];
            imm_i = {{20{w[31]}}, w[31:20]};
            imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
            imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
            imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
            r.dest_index = w[11:7];
            r.next_pc = pc_mirror + 32'd4;
            case (op)
               OPC_OPIMM: begin
                  wr = 1'b1;
                  if (f3 == 3'd1 || f3 == 3'd5)
                     r.dest_value = compute_alu(f3, w[30], a, {27'd0, w[24:20]});
                  else
                     r.dest_value = compute_alu(f3, 1'b0, a, imm_i);
               end
               OPC_OP: begin
                  wr = 1'b1;
                  r.dest_value = compute_alu(f3, w[31:25] == FUNCT7_ALT, a, b);
               end
               OPC_LOAD: begin
                  addr = a + imm_i;
                  size = (f3[1:0] == 2'd0) ? 1 : (f3[1:0] == 2'd1 ? 2 : 4);
                  if (f3 == 3'd3 || f3 >= 3'd6) r.status = ST_ILLEGAL;
                  else if (!fits(addr, size)) r.status = ST_RANGE;
                  else begin
                     v = read_bytes(addr, size);
                     if (f3 == 3'd0 && v[7]) v[31:8] = '1;
                     if (f3 == 3'd1 && v[15]) v[31:16] = '1;
                     wr = 1'b1;
                     r.dest_value = v;
                  end
               end
               OPC_STORE: begin
                  addr = a + imm_s;
                  size = (f3 == 3'd0) ? 1 : (f3 == 3'd1 ? 2 : 4);
                  if (f3 > 3'd2) r.status = ST_ILLEGAL;
                  else if (!fits(addr, size)) r.status = ST_RANGE;
                  else write_bytes(addr, size, b);
               end
               OPC_BRANCH: begin
                  take = 1'b0;
                  case (f3)
                     3'd0: take = a == b;
                     3'd1: take = a != b;
                     3'd4: take = $signed(a) < $signed(b);
                     3'd5: take = !($signed(a) < $signed(b));
                     3'd6: take = a < b;
                     3'd7: take = a >= b;
                     default: r.status = ST_ILLEGAL;
                  endcase
                  if (take) r.next_pc = pc_mirror + imm_b;
               end
               OPC_JAL: begin
                  wr = 1'b1;
                  r.dest_value = pc_mirror + 32'd4;
                  r.next_pc = pc_mirror + imm_j;
               end
               OPC_JALR: begin
                  wr = 1'b1;
                  r.dest_value = pc_mirror + 32'd4;
                  r.next_pc = (a + imm_i) & ~32'd1;
               end
               OPC_LUI: begin
                  wr = 1'b1;
                  r.dest_value = w & UPPER_MASK;
               end
               OPC_AUIPC: begin
                  wr = 1'b1;
                  r.dest_value = pc_mirror + (w & UPPER_MASK);
               end
               OPC_FENCE: ;
               OPC_SYSTEM: begin
                  if (regs[REG_CALL_NUMBER] == exit_number) begin
                     r.status = ST_EXIT;
                     halted_mirror = 1'b1;
                  end
               end
               default: r.status = ST_ILLEGAL;
            endcase
            if (wr && r.dest_index != 5'd0) regs[r.dest_index] = r.dest_value;
            else wr = 1'b0;
         end
      end
      if (!wr) begin
         r.dest_index = '0;
         r.dest_value = '0;
      end
      r.reg_written = wr;
      pc_mirror = r.next_pc;
      r.is_halted = halted_mirror;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // predict on each request transaction, compare on each result transaction
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (csr_write_enable) exit_number <= csr_write_data;
         if (req_valid && req_ready) expected_rsps.push_back(execute_step(req_payload));
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_rsps.size() == 0) begin
               $error("result transaction with no request outstanding");
               fail_count++;
            end else begin
               e = expected_rsps.pop_front();
               compare_field("status", 32'(e.status), 32'(rsp_payload.status));
               compare_field("instr_pc", e.instr_pc, rsp_payload.instr_pc);
               compare_field("instr_word", e.instr_word, rsp_payload.instr_word);
               compare_field("reg_written", 32'(e.reg_written),
                             32'(rsp_payload.reg_written));
               compare_field("dest_index", 32'(e.dest_index), 32'(rsp_payload.dest_index));
               compare_field("dest_value", e.dest_value, rsp_payload.dest_value);
               compare_field("next_pc", e.next_pc, rsp_payload.next_pc);
               compare_field("is_halted", 32'(e.is_halted), 32'(rsp_payload.is_halted));
            end
         end
      end
      pending_results = expected_rsps.size();
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
   import ris_pkg::*;

   localparam int BLOCK_WORDS = 32;
   localparam int ROUNDS      = 17;
   localparam int STALL_LIMIT = 6000;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;
   logic        calm;
   int          fail_count, pending_results, results_seen;
   int          requests_sent, quiet_cycles;

   ris_stream_if #(.WIDTH($bits(req_type))) req_ch ();
   ris_stream_if #(.WIDTH($bits(rsp_type))) rsp_ch ();

   rv32i_instruction_step dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   step_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_payload      (req_type'(req_ch.payload)),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_payload      (rsp_type'(rsp_ch.payload)),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_results  (pending_results),
      .results_seen     (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side back-pressure in bursts
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
            repeat ($urandom_range(1, 20) - 1) @(negedge clock);
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_results);
         $display("CHECKS FAILED");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   // caller stands at a falling edge; returns at a falling edge after acceptance
   task automatic send_req(input logic cmd, input logic [11:0] addr, input logic [31:0] data);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.payload = req_type'{cmd: cmd, load_address: addr, load_data: data};
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic load_word(input int addr, input logic [31:0] data);
      send_req(CMD_LOAD, 12'(addr), data);
   endtask

   task automatic step_core();
      send_req(CMD_STEP, 12'($urandom()), $urandom());
   endtask

   task automatic wait_idle();
      req_ch.valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_exit_number(input logic [31:0] v);
      csr_write_enable = 1'b1;
      csr_write_data = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // encoders
   function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                         input logic [2:0] f3, input logic [4:0] rd,
                                         input logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
   endfunction

   function automatic logic [31:0] enc_b(input logic [12:0] o, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3);
      return {o[12], o[10:5], rs2, rs1, f3, o[4:1], o[11], OPC_BRANCH};
   endfunction

   function automatic logic [31:0] enc_j(input logic [20:0] o, input logic [4:0] rd);
      return {o[20], o[10:1], o[11], o[19:12], rd, OPC_JAL};
   endfunction

   // x17 holds the call number, x29 and x30 are fixed bases for data accesses
   function automatic logic [4:0] pick_rd();
      logic [4:0] r;
      do r = 5'($urandom()); while (r == 5'd17 || r == 5'd29 || r == 5'd30);
      return r;
   endfunction

   // random instruction at word idx; control flow stays inside the code block
   function automatic logic [31:0] random_instr(input int idx);
      logic [4:0]  rs1, rs2;
      logic [2:0]  f3;
      logic [11:0] imm;
      logic [6:0]  op;
      int          tgt;
      rs1 = 5'($urandom());
      rs2 = 5'($urandom());
      f3 = 3'($urandom());
      tgt = $urandom_range(0, BLOCK_WORDS);
      case ($urandom_range(0, 13))
         0, 1: return enc_i(12'($urandom()), rs1, f3, pick_rd(), OPC_OPIMM);
         2, 3: begin
            op = ($urandom_range(0, 3) == 0) ? 7'($urandom()) : 7'($urandom_range(0, 1) << 5);
            return {op, rs2, rs1, f3, pick_rd(), OPC_OP};
         end
         4, 5: begin
            case ($urandom_range(0, 3))
               0: return enc_i(12'($urandom()), rs1, f3, pick_rd(), OPC_LOAD);
               1: return enc_i(12'($urandom_range(0, 7)), 5'd29, f3, pick_rd(), OPC_LOAD);
               default: return enc_i(12'($urandom_range(0, 2047)), 5'd0, f3, pick_rd(),
                                     OPC_LOAD);
            endcase
         end
         6, 7: begin
            case ($urandom_range(0, 3))
               0: return enc_s(12'($urandom()), rs2, 5'd30, f3);
               1: return enc_s(12'($urandom_range(0, 7)), rs2, 5'd29, f3);
               default: return enc_s(12'($urandom_range(1024, 2047)), rs2, 5'd0, f3);
            endcase
         end
         8: return enc_b(13'((tgt - idx) * 4), rs2, rs1, f3);
         9: return enc_j(21'((tgt - idx) * 4), pick_rd());
         10: begin
            imm = 12'(tgt * 4) | 12'($urandom_range(0, 1));
            return enc_i(imm, 5'd0, f3, pick_rd(), OPC_JALR);
         end
         11: return {20'($urandom()), pick_rd(), ($urandom_range(0, 1) ? OPC_LUI : OPC_AUIPC)};
         12: return {25'($urandom()), ($urandom_range(0, 1) ? OPC_FENCE : OPC_SYSTEM)};
         default: begin
            do op = 7'($urandom()); while (op inside {OPC_OPIMM, OPC_OP, OPC_STORE,
               OPC_BRANCH, OPC_LOAD, OPC_JALR, OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_SYSTEM,
               OPC_FENCE} || op == 7'd0);
            return {25'($urandom()), op};
         end
      endcase
   endfunction

   initial begin
      logic [31:0] exit_v;
      reset = 1'b1;
      calm = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      requests_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_exit_number(EXIT_RESET);

      // directed: range limits of the load command and a short fixed program
      load_word(4093, 32'hFFFF_FFFF);
      load_word(4095, 32'h1234_5678);
      load_word(4092, 32'h0000_0001);
      load_word(0,  {20'h00001, 5'd29, OPC_LUI});
      load_word(4,  enc_i(-12'sd4, 5'd29, 3'd0, 5'd29, OPC_OPIMM));
      load_word(8,  {20'h00100, 5'd30, OPC_LUI});
      load_word(12, enc_i(12'd5, 5'd0, 3'd0, 5'd17, OPC_OPIMM));
      load_word(16, enc_i(12'hFFF, 5'd0, 3'd0, 5'd1, OPC_OPIMM));
      load_word(20, enc_s(12'd1024, 5'd1, 5'd0, 3'd2));
      load_word(24, enc_i(12'd1027, 5'd0, 3'd0, 5'd2, OPC_LOAD));
      load_word(28, enc_i(12'd1026, 5'd0, 3'd5, 5'd3, OPC_LOAD));
      load_word(32, enc_s(12'd4, 5'd1, 5'd29, 3'd2));
      load_word(36, {25'd0, OPC_SYSTEM});
      load_word(40, 32'hFFFF_FFFF);
      repeat (11) step_core();
      wait_idle();

      // random rounds: fresh code block, data loads, then execution
      for (int rnd = 0; rnd < ROUNDS; rnd++) begin
         calm = (rnd >= ROUNDS - 3);
         case (rnd % 4)
            0: exit_v = 32'd0;
            1: exit_v = 32'hFFFF_FFFF;
            default: do exit_v = $urandom(); while (exit_v == 32'd5);
         endcase
         write_exit_number(exit_v);
         for (int i = 0; i < BLOCK_WORDS; i++) load_word(4 * i, random_instr(i));
         load_word(4 * BLOCK_WORDS, enc_j(21'(-4 * BLOCK_WORDS), 5'd0));
         repeat (3) load_word($urandom_range(1024, 4095), $urandom());
         repeat (60) step_core();
         wait_idle();
      end

      // finish with an exit call, then steps and a load on the halted core
      write_exit_number(32'd5);
      for (int i = 0; i <= BLOCK_WORDS; i++) load_word(4 * i, {25'd0, OPC_SYSTEM});
      step_core();
      step_core();
      load_word(2048, 32'hA5A5_A5A5);
      step_core();
      wait_idle();

      $display("%0d request transactions (program loads and steps over %0d code blocks),",
               requests_sent, ROUNDS);
      $display("%0d result transactions checked field by field", results_seen);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
